### hdl/keyed_count_table_core_assert.svh
// Assertion macros for the keyed count table.
// Used by the top level only; needs a clock named clk and a reset named rst.
`ifndef KEYED_COUNT_TABLE_CORE_ASSERT_SVH
`define KEYED_COUNT_TABLE_CORE_ASSERT_SVH
// Same-cycle implication.
`define KCT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define KCT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### hdl/kct_pkg.sv
// Package for the keyed count table: sizes, codes, entry, result and state types,
// and the key hash. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package kct_pkg;
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CAP_W = 13;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W = 32;
  localparam int AMT_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd3000;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ABSENT   = 3'd1,
    ST_FULL     = 3'd2,
    ST_SHORT    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_GONE  = 2'd2
  } slot_state_t;

  typedef struct packed {
    slot_state_t       tag;
    logic [KEY_W-1:0]  key;
    logic [AMT_W-1:0]  count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t          status;
    logic [AMT_W-1:0] count_after;
    logic [CAP_W-1:0] entries_used;
  } result_t;

  typedef enum logic [2:0] {
    E_CLEAR,
    E_IDLE,
    E_READ,
    E_CHECK,
    E_DONE
  } eng_state_t;

  // Fold the key onto the index width, then bring it below the slot count.
  function automatic logic [IDX_W-1:0] key_hash(input logic [KEY_W-1:0] key);
    logic [IDX_W-1:0] h;
    logic [IDX_W:0]   w;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ key[i];
    end
    w = {1'b0, h};
    if (w >= (IDX_W+1)'(TABLE_ENTRIES)) begin
      w = w - (IDX_W+1)'(TABLE_ENTRIES);
    end
    return w[IDX_W-1:0];
  endfunction
endpackage
`default_nettype wire

### hdl/kct_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module kct_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 66,
  parameter int AW    = 12
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/kct_engine.sv
// Probe engine: clearing pass, hashed linear probing with tombstones,
// and the read-modify-write of one entry. Depends on kct_pkg and kct_ram.
`timescale 1ns / 1ps
`default_nettype none
module kct_engine
  import kct_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire logic             op_valid,
  output logic                  op_ready,
  input  wire logic [1:0]       op_kind,
  input  wire logic [KEY_W-1:0] op_key,
  input  wire logic [AMT_W-1:0] op_amount,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output result_t               res
);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  eng_state_t       state, state_next;
  logic [IDX_W-1:0] probe_idx, probe_idx_next;
  logic [IDX_W:0]   probe_cnt, probe_cnt_next;
  logic             have_free, have_free_next;
  logic [IDX_W-1:0] free_idx, free_idx_next;
  logic [CNT_W-1:0] used, used_next;
  logic [CAP_W-1:0] capacity;
  result_t          res_next;
  logic [1:0]       kind_q;
  logic [KEY_W-1:0] key_q;
  logic [AMT_W-1:0] amt_q;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wentry;
  logic [ENTRY_W-1:0] rdata;
  entry_t           rd;

  kct_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENTRY_W), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (probe_idx),
    .rdata (rdata)
  );

  assign rd        = entry_t'(rdata);
  assign op_ready  = (state == E_IDLE);
  assign res_valid = (state == E_DONE);

  logic             hit, empty, gone, last, full;
  logic [IDX_W-1:0] ins_idx, step_idx;
  logic [AMT_W:0]   sum;

  always_comb begin
    hit      = (rd.tag == SLOT_USED) && (rd.key == key_q);
    empty    = (rd.tag == SLOT_EMPTY);
    gone     = (rd.tag == SLOT_GONE);
    last     = (probe_cnt == (IDX_W+1)'(TABLE_ENTRIES - 1));
    ins_idx  = have_free ? free_idx : probe_idx;
    step_idx = (probe_idx == LAST_IDX) ? '0 : probe_idx + 1'b1;
    sum      = {1'b0, rd.count} + {1'b0, amt_q};
    full     = (CMP_W'(used) >= CMP_W'(capacity)) ||
               (CMP_W'(used) >= CMP_W'(TABLE_ENTRIES));
  end

  always_comb begin
    state_next     = state;
    probe_idx_next = probe_idx;
    probe_cnt_next = probe_cnt;
    have_free_next = have_free;
    free_idx_next  = free_idx;
    used_next      = used;
    res_next       = res;
    we             = 1'b0;
    waddr          = probe_idx;
    wentry         = rd;
    case (state)
      E_CLEAR: begin
        we         = 1'b1;
        wentry.tag = SLOT_EMPTY;
        if (probe_idx == LAST_IDX) begin
          probe_idx_next = '0;
          state_next     = E_IDLE;
        end else begin
          probe_idx_next = probe_idx + 1'b1;
        end
      end
      E_IDLE: begin
        if (op_valid) begin
          probe_idx_next = key_hash(op_key);
          probe_cnt_next = '0;
          have_free_next = 1'b0;
          state_next     = E_READ;
        end
      end
      E_READ: begin
        state_next = E_CHECK;
      end
      E_CHECK: begin
        if (hit) begin
          res_next.count_after = rd.count;
          res_next.status      = ST_OK;
          if (kind_q == KIND_ADD) begin
            we           = 1'b1;
            wentry.count = sum[AMT_W] ? '1 : sum[AMT_W-1:0];
            res_next.count_after = wentry.count;
            if (sum[AMT_W]) begin
              res_next.status = ST_OVERFLOW;
            end
          end else if (kind_q == KIND_DEL) begin
            if (rd.count < amt_q) begin
              res_next.status = ST_SHORT;
            end else if (rd.count == amt_q) begin
              we         = 1'b1;
              wentry.tag = SLOT_GONE;
              res_next.count_after = '0;
              if (used != '0) begin
                used_next = used - 1'b1;
              end
            end else begin
              we           = 1'b1;
              wentry.count = rd.count - amt_q;
              res_next.count_after = wentry.count;
            end
          end else if (rd.count < amt_q) begin
            res_next.status = ST_SHORT;
          end
          state_next = E_DONE;
        end else if (empty || last) begin
          // The key is not in the table.
          res_next.count_after = '0;
          if (kind_q == KIND_ADD) begin
            if (full) begin
              res_next.status = ST_FULL;
            end else begin
              we           = 1'b1;
              waddr        = ins_idx;
              wentry.tag   = SLOT_USED;
              wentry.key   = key_q;
              wentry.count = amt_q;
              used_next    = used + 1'b1;
              res_next.status      = ST_OK;
              res_next.count_after = amt_q;
            end
          end else begin
            res_next.status = ST_ABSENT;
          end
          state_next = E_DONE;
        end else begin
          if (gone && !have_free) begin
            have_free_next = 1'b1;
            free_idx_next  = probe_idx;
          end
          probe_idx_next = step_idx;
          probe_cnt_next = probe_cnt + 1'b1;
          state_next     = E_READ;
        end
        res_next.entries_used = CAP_W'(used_next);
      end
      E_DONE: begin
        if (res_ready) begin
          state_next = E_IDLE;
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_CLEAR;
      probe_idx <= '0;
      probe_cnt <= '0;
      have_free <= 1'b0;
      used      <= '0;
      capacity  <= CAP_RESET;
    end else begin
      state     <= state_next;
      probe_idx <= probe_idx_next;
      probe_cnt <= probe_cnt_next;
      have_free <= have_free_next;
      used      <= used_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    free_idx <= free_idx_next;
    res      <= res_next;
    if (op_valid && op_ready) begin
      kind_q <= op_kind;
      key_q  <= op_key;
      amt_q  <= op_amount;
    end
  end
endmodule
`default_nettype wire

### hdl/keyed_count_table_core.sv
// Per item: the engine accepts it in the idle state, then for each of its P probes
// (1 to TABLE_ENTRIES) reads one slot of the memory and checks it, and then holds the
// result until the output register takes it. One item at a time: the next item is
// accepted only once that result has left the engine, as the read and check loop on
// the memory serves one item. Reset: synchronous, active high; afterwards a clearing
// pass over all TABLE_ENTRIES slots (4096) marks every slot empty before any item is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_count_table_core_assert.svh"
module keyed_count_table_core
  import kct_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,   // capacity
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [71:0]      s_tdata,     // kind[1:0], object_key[33:2], amount[65:34]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [47:0]      m_tdata      // status[2:0], count_after[34:3], entries_used[47:35]
);
  logic    res_valid, res_ready;
  result_t res;

  // The engine owns the table memory and handles one item at a time.
  kct_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op_valid  (s_tvalid),
    .op_ready  (s_tready),
    .op_kind   (s_tdata[1:0]),
    .op_key    (s_tdata[33:2]),
    .op_amount (s_tdata[65:34]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: a finished result waits here, so the engine can go on
  // to the next item while the downstream side stalls.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {res.entries_used, res.count_after, res.status};
    end
  end

  // The table can never report more entries than it has slots.
  `KCT_IMPLY(a_used_bound, m_tvalid, m_tdata[47:35] <= CAP_W'(TABLE_ENTRIES), "entries_used too big")
  // Status codes stay within the defined set.
  `KCT_IMPLY(a_status_code, m_tvalid, m_tdata[2:0] <= ST_OVERFLOW, "bad status code")
  // The engine is not ready again in the cycle after it takes an item.
  `KCT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted twice in a row")
endmodule
`default_nettype wire

### dv/kct_checker.sv
// Checker for the keyed count table: watches the configuration port and both
// item channels, predicts each result and compares it. Depends on kct_pkg.
`timescale 1ns / 1ps
module kct_checker
  import kct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [71:0]      s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [47:0]      m_tdata,
  output int               fail_count,
  output int               pending
);
  logic [AMT_W-1:0] count_by_key [logic [KEY_W-1:0]];
  logic [CAP_W-1:0] capacity;
  result_t          awaited_results [$];

  function automatic result_t apply_op(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                                       input logic [AMT_W-1:0] amt);
    result_t          r;
    logic             present;
    logic [AMT_W-1:0] cur;
    logic [AMT_W:0]   sum;
    present = count_by_key.exists(key);
    cur = present ? count_by_key[key] : '0;
    r.status = ST_OK;
    r.count_after = '0;
    if (kind == KIND_ADD) begin
      if (present) begin
        sum = {1'b0, cur} + {1'b0, amt};
        if (sum[AMT_W]) begin
          r.status = ST_OVERFLOW;
          r.count_after = '1;
        end else begin
          r.count_after = sum[AMT_W-1:0];
        end
        count_by_key[key] = r.count_after;
      end else if (count_by_key.num() >= int'(capacity)
                   || count_by_key.num() >= TABLE_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        count_by_key[key] = amt;
        r.count_after = amt;
      end
    end else if (kind == KIND_DEL) begin
      if (!present) begin
        r.status = ST_ABSENT;
      end else if (cur < amt) begin
        r.status = ST_SHORT;
        r.count_after = cur;
      end else if (cur == amt) begin
        count_by_key.delete(key);
      end else begin
        count_by_key[key] = cur - amt;
        r.count_after = cur - amt;
      end
    end else begin
      // Query, and the spare fourth kind, which behaves as a query.
      if (!present) begin
        r.status = ST_ABSENT;
      end else begin
        r.count_after = cur;
        if (cur < amt) r.status = ST_SHORT;
      end
    end
    r.entries_used = CAP_W'(count_by_key.num());
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    status_t got_status;
    if (rst) begin
      count_by_key.delete();
      awaited_results.delete();
      capacity <= CAP_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (m_tvalid && m_tready) begin
        got_status = status_t'(m_tdata[2:0]);
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d count %0h used %0d", $time,
                   m_tdata[2:0], m_tdata[34:3], m_tdata[47:35]);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got_status !== want.status || m_tdata[34:3] !== want.count_after
              || m_tdata[47:35] !== want.entries_used) begin
            $display("%0t: mismatch, expected status %0d count %0h used %0d, got %0d %0h %0d",
                     $time, want.status, want.count_after, want.entries_used,
                     m_tdata[2:0], m_tdata[34:3], m_tdata[47:35]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(apply_op(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]));
    end
  end

  assign pending = awaited_results.size();
endmodule

### dv/tb.sv
// Testbench top for keyed_count_table_core: clock, reset, stimulus and verdict.
// Depends on kct_pkg, keyed_count_table_core and kct_checker.
`timescale 1ns / 1ps
module tb;
  import kct_pkg::*;

  // The package only names add and delete; the other two kinds live here.
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL_SIZE = 48;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [71:0]      s_tdata;   // kind[1:0], object_key[33:2], amount[65:34]
  logic             m_tvalid;
  logic             m_tready;
  logic [47:0]      m_tdata;   // status[2:0], count_after[34:3], entries_used[47:35]
  int               fail_count;
  int               pending;
  int               items_sent;
  int               burst_left;
  int               cycles;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always #2 clk = ~clk;

  keyed_count_table_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  kct_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog. The clearing pass after reset and every probe loop fit far
  // inside this limit on a correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side. It switches among four stall patterns, one of them being
  // always ready. Once, after 200 items were sent, it holds off so that the
  // block fills up and stops taking items.
  initial begin
    int mode;
    int hold;
    bit held;
    m_tready <= 1'b0;
    held = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (!held && items_sent >= 200) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Offer one item and return at the edge that accepts it. The valid line
  // stays high, so a caller that goes straight on keeps the burst running.
  task automatic send_item(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [AMT_W-1:0] amt);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, amt, key, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every result is back, plus a margin.
  task automatic drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Amounts lean on the small and the near-maximum ranges, where the
  // short-count and saturation cases live.
  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 3))
      0: return AMT_W'($urandom_range(0, 20));
      1: return '1 - AMT_W'($urandom_range(0, 20));
      default: return $urandom;
    endcase
  endfunction

  // Well-formed life of one fresh key: one or two adds, a query, then the deletes,
  // which usually free the entry again. The rest is single operations on a
  // small pool of keys, so that present keys are hit often.
  task automatic random_phase(input int n);
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] a;
    logic [AMT_W-1:0] b;
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 9) < 6) begin
        key = $urandom;
        a = pick_amount();
        b = pick_amount();
        send_item(KIND_ADD, key, a);
        if ($urandom_range(0, 1)) send_item(KIND_ADD, key, b);
        send_item(KIND_QUERY, key, $urandom_range(0, 1) ? a + b : pick_amount());
        send_item(KIND_DEL, key, a);
        if ($urandom_range(0, 3) != 0) send_item(KIND_DEL, key, b);
      end else begin
        send_item(2'($urandom_range(0, 3)), key_pool[$urandom_range(0, POOL_SIZE - 1)],
                  pick_amount());
      end
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k_lo;
    logic [KEY_W-1:0] k_hi;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    items_sent = 0;
    burst_left = 0;
    cycles = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity: new key with amount zero,
    // saturation, query and delete at the extremes, absent keys, short
    // counts, the spare kind acting as a query, and freeing an entry.
    k_lo = '0;
    k_hi = '1;
    send_item(KIND_ADD, k_lo, '0);
    send_item(KIND_ADD, k_lo, '1);
    send_item(KIND_ADD, k_lo, 32'd1);
    send_item(KIND_QUERY, k_lo, '1);
    send_item(KIND_DEL, k_lo, '0);
    send_item(KIND_DEL, k_hi, 32'd1);
    send_item(KIND_QUERY, k_hi, '0);
    send_item(KIND_SPARE, k_lo, '0);
    send_item(KIND_ADD, k_hi, 32'd5);
    send_item(KIND_DEL, k_hi, 32'd6);
    send_item(KIND_QUERY, k_hi, 32'd6);
    send_item(KIND_DEL, k_hi, 32'd5);
    send_item(KIND_DEL, k_lo, '1);

    // No room at all, then room for one key.
    set_capacity('0);
    send_item(KIND_ADD, 32'h1234_5678, 32'd3);
    set_capacity(13'd1);
    send_item(KIND_ADD, 32'hA5A5_5A5A, 32'd7);
    send_item(KIND_ADD, 32'h5A5A_A5A5, 32'd1);
    send_item(KIND_ADD, 32'hA5A5_5A5A, 32'd3);
    send_item(KIND_DEL, 32'hA5A5_5A5A, 32'd10);
    send_item(KIND_ADD, 32'h5A5A_A5A5, 32'd1);

    // Random phases across capacities, the extremes among them.
    set_capacity(13'h1FFF);
    random_phase(90);
    set_capacity(13'd40);
    random_phase(120);
    set_capacity(13'd5);
    random_phase(90);
    set_capacity(13'd4096);
    random_phase(90);
    set_capacity('0);
    random_phase(40);
    set_capacity(13'd3000);
    random_phase(90);
    drain();

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/kct_pkg.sv
hdl/kct_ram.sv
hdl/kct_engine.sv
hdl/keyed_count_table_core.sv
dv/kct_checker.sv
dv/tb.sv
